@@ rtl/core/ptmw_pkg.sv @@
// ----------------------------------------------------------------------------
// ptmw_pkg
// Types and constants shared by the page table mapper and walker.
// ----------------------------------------------------------------------------
package ptmw_pkg;

	localparam int unsigned ADDR_W  = 52;
	localparam int unsigned VA_W    = 48;
	localparam int unsigned FRAME_W = 40;
	localparam int unsigned IDX_W   = 9;
	localparam int unsigned CFG_W   = 52;

	// configuration register indexes
	localparam logic [1:0] CFG_ROOT_TABLE = 2'd0;
	localparam logic [1:0] CFG_STORE_BASE = 2'd1;
	localparam logic [1:0] CFG_FIRST_FREE = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
	localparam logic [1:0] ST_OUTSIDE     = 2'd2;
	localparam logic [1:0] ST_NOT_PRESENT = 2'd3;

	localparam logic FUNC_MAP    = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// entry flag bits: present and writable
	localparam logic [11:0] ENTRY_FLAGS_PW = 12'h003;

	typedef struct packed {
		logic              func;
		logic [VA_W-1:0]   vaddr;
		logic [ADDR_W-1:0] paddr;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [63:0]       pte_value;
		logic [ADDR_W-1:0] pte_addr;
		logic [1:0]        new_tables;
	} resp_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CHECK,
		S_EVAL,
		S_CLEAR,
		S_LINK,
		S_DONE
	} walk_state_t;

endpackage

@@ rtl/core/page_table_mapper_walker.sv @@
// ----------------------------------------------------------------------------
// page_table_mapper_walker
// Four-level page table map and lookup engine over an internal table store.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request word (map or lookup); out_valid/
//   out_ready carry one response word per request. cfg_we/cfg_index/cfg_wdata
//   write root table address, store base and first free table page.
//   A walk runs in a small sequencer over a single-port table store:
//   each upper level goes through a range check with a store read (S_CHECK)
//   and an evaluation of the read entry (S_EVAL); a map writes the leaf in
//   the check step, a lookup reads the leaf and evaluates it, and S_DONE
//   posts the result. Each newly allocated table is cleared, all 512 entries
//   through the one store write port, and then linked with one more write.
//   The output register lets the response wait while the engine goes back
//   to idle and takes the next request; a second response waits in the
//   sequencer until out_ready frees the register.
//   After reset the store is swept to zero, one entry per cycle, over all
//   TABLE_PAGES*512 entries; no request is taken meanwhile, config writes are.
// ----------------------------------------------------------------------------
module page_table_mapper_walker
	import ptmw_pkg::*;
#(
	parameter int unsigned TABLE_PAGES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  req_t              in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output resp_t             out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	localparam int unsigned PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int unsigned AW     = PAGE_W + IDX_W;
	localparam int unsigned WORDS  = TABLE_PAGES * 512;
	localparam int unsigned CNT_W  = ($clog2(TABLE_PAGES + 1) > 6) ?
		$clog2(TABLE_PAGES + 1) : 6;

	walk_state_t state_q, state_d;

	logic [ADDR_W-1:0]  root_q;
	logic [ADDR_W-1:0]  base_q;
	logic [CNT_W-1:0]   next_free_q;

	req_t               req_q;
	logic [1:0]         lvl_q;
	logic [FRAME_W-1:0] table_q;
	logic [FRAME_W-1:0] naddr_q;
	logic [PAGE_W-1:0]  page_q;
	logic [AW-1:0]      slot_q;
	logic [AW-1:0]      clr_q;
	logic [ADDR_W-1:0]  eaddr_q;
	logic [63:0]        value_q;
	logic [1:0]         status_q;
	logic [1:0]         created_q;
	logic [63:0]        rdata_q;

	resp_t              out_q;
	logic               out_valid_q;

	logic [63:0]        mem [WORDS];

	logic [IDX_W-1:0]   idx_c;
	logic [ADDR_W-1:0]  eaddr_c;
	logic [ADDR_W-1:0]  off_c;
	logic               in_store_c;
	logic [AW-1:0]      slot_c;
	logic [63:0]        leaf_c;
	logic               lookup_c;
	logic               exhausted_c;
	logic               post_c;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [63:0]        mem_wdata;
	logic               mem_re;

	// address arithmetic for the current level
	always_comb begin
		unique case (lvl_q)
			2'd0:    idx_c = req_q.vaddr[47:39];
			2'd1:    idx_c = req_q.vaddr[38:30];
			2'd2:    idx_c = req_q.vaddr[29:21];
			default: idx_c = req_q.vaddr[20:12];
		endcase
		eaddr_c     = {table_q, idx_c, 3'b000};
		off_c       = eaddr_c - {base_q[ADDR_W-1:12], 12'h000};
		in_store_c  = off_c[ADDR_W-1:12] < FRAME_W'(TABLE_PAGES);
		slot_c      = off_c[AW+2:3];
		leaf_c      = {12'h000, req_q.paddr[ADDR_W-1:12], ENTRY_FLAGS_PW};
		lookup_c    = (req_q.func == FUNC_LOOKUP);
		exhausted_c = next_free_q >= CNT_W'(TABLE_PAGES);
		post_c      = !out_valid_q || out_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (clr_q == AW'(WORDS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!in_store_c) state_d = S_DONE;
				else if (lvl_q == 2'd3 && !lookup_c) state_d = S_DONE;
				else state_d = S_EVAL;
			end
			S_EVAL: begin
				if (lvl_q == 2'd3) state_d = S_DONE;
				else if (rdata_q[0]) state_d = S_CHECK;
				else if (lookup_c || exhausted_c) state_d = S_DONE;
				else state_d = S_CLEAR;
			end
			S_CLEAR: begin
				if (clr_q[IDX_W-1:0] == {IDX_W{1'b1}}) state_d = S_LINK;
			end
			S_LINK: begin
				state_d = S_CHECK;
			end
			S_DONE: begin
				if (post_c) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	// store port control
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 64'h0;
		mem_re    = 1'b0;
		unique case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
			end
			S_CHECK: begin
				mem_waddr = slot_c;
				mem_wdata = leaf_c;
				mem_we    = in_store_c && lvl_q == 2'd3 && !lookup_c;
				mem_re    = in_store_c && !mem_we;
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = {page_q, clr_q[IDX_W-1:0]};
			end
			S_LINK: begin
				mem_we    = 1'b1;
				mem_waddr = slot_q;
				mem_wdata = {12'h000, naddr_q, ENTRY_FLAGS_PW};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// table store
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[slot_c];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			root_q      <= '0;
			base_q      <= '0;
			next_free_q <= CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT || state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			else clr_q <= '0;
			if (state_q == S_EVAL && state_d == S_CLEAR) next_free_q <= next_free_q + CNT_W'(1);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROOT_TABLE: root_q <= cfg_wdata;
					CFG_STORE_BASE: base_q <= cfg_wdata;
					CFG_FIRST_FREE: next_free_q <= CNT_W'(cfg_wdata[5:0]);
					default: ;
				endcase
			end
			if (state_q == S_DONE && post_c) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q     <= in_data;
				lvl_q     <= 2'd0;
				table_q   <= root_q[ADDR_W-1:12];
				status_q  <= ST_OK;
				created_q <= 2'd0;
				value_q   <= 64'h0;
			end
			S_CHECK: begin
				eaddr_q <= eaddr_c;
				slot_q  <= slot_c;
				if (!in_store_c) status_q <= ST_OUTSIDE;
				else if (lvl_q == 2'd3 && !lookup_c) value_q <= leaf_c;
			end
			S_EVAL: begin
				if (lvl_q == 2'd3) begin
					value_q <= rdata_q;
				end else if (rdata_q[0]) begin
					table_q <= rdata_q[ADDR_W-1:12];
					lvl_q   <= lvl_q + 2'd1;
				end else if (lookup_c) begin
					status_q <= ST_NOT_PRESENT;
				end else if (exhausted_c) begin
					status_q <= ST_EXHAUSTED;
				end else begin
					page_q    <= next_free_q[PAGE_W-1:0];
					naddr_q   <= base_q[ADDR_W-1:12] + FRAME_W'(next_free_q[PAGE_W-1:0]);
					created_q <= created_q + 2'd1;
				end
			end
			S_LINK: begin
				table_q <= naddr_q;
				lvl_q   <= lvl_q + 2'd1;
			end
			S_DONE: begin
				if (post_c) begin
					out_q.status     <= status_q;
					out_q.pte_value  <= (status_q == ST_OK) ? value_q : 64'h0;
					out_q.pte_addr   <= (status_q == ST_OK) ? eaddr_q : '0;
					out_q.new_tables <= created_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_CHECK && lvl_q == 2'd0)
		else $error("accepted word did not start a walk at the root");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.pte_value == 64'h0
		&& out_data.pte_addr == '0)
		else $error("error response carries a nonzero entry or address");

	a_lookup_no_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL && req_q.func == FUNC_LOOKUP |-> created_q == 2'd0)
		else $error("lookup allocated a table");

	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |=> next_free_q == $past(next_free_q)
		|| next_free_q == $past(next_free_q) + CNT_W'(1))
		else $error("allocator moved by more than one page");

endmodule
